@@ rtl/core/tekd_pkg.sv @@
// Shared types, constants and lookup functions of the terminal key decoder.
`timescale 1ns / 1ps
package tekd_pkg;

  localparam int ESC_BODY_DEPTH_DEF = 16;
  // most key events one byte may cause; bounds the bytes of an end-of-write flush
  localparam int RESULT_LIMIT   = 16;
  localparam int FLUSH_W        = 4;
  localparam logic [FLUSH_W-1:0] FLUSH_MAX = FLUSH_W'(RESULT_LIMIT - 1);
  localparam int CMD_FIFO_DEPTH = 4;

  // stream bytes
  localparam logic [7:0] BYTE_ESC   = 8'h1B;
  localparam logic [7:0] BYTE_DEL   = 8'h7F;
  localparam logic [7:0] CHAR_BS    = 8'h08;
  localparam logic [7:0] INTRO_CSI  = 8'h5B;  // '['
  localparam logic [7:0] INTRO_SS3  = 8'h4F;  // 'O'
  localparam logic [7:0] SS3_P      = 8'h50;
  localparam logic [7:0] SS3_S      = 8'h53;
  localparam logic [7:0] FIN_UP     = 8'h41;
  localparam logic [7:0] FIN_DOWN   = 8'h42;
  localparam logic [7:0] FIN_RIGHT  = 8'h43;
  localparam logic [7:0] FIN_LEFT   = 8'h44;
  localparam logic [7:0] FIN_END    = 8'h46;
  localparam logic [7:0] FIN_HOME   = 8'h48;
  localparam logic [7:0] FIN_TILDE  = 8'h7E;
  localparam logic [7:0] CH_AT      = 8'h40;
  localparam logic [7:0] CH_Z       = 8'h5A;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [4:0] CSI_NUM_MAX = 5'd31;

  // scan codes
  localparam logic [4:0] SCAN_NONE        = 5'd0;
  localparam logic [4:0] SCAN_ARROW_UP    = 5'd1;
  localparam logic [4:0] SCAN_ARROW_DOWN  = 5'd2;
  localparam logic [4:0] SCAN_ARROW_RIGHT = 5'd3;
  localparam logic [4:0] SCAN_ARROW_LEFT  = 5'd4;
  localparam logic [4:0] SCAN_HOME_KEY    = 5'd5;
  localparam logic [4:0] SCAN_END_KEY     = 5'd6;
  localparam logic [4:0] SCAN_INS         = 5'd7;
  localparam logic [4:0] SCAN_DEL         = 5'd8;
  localparam logic [4:0] SCAN_PAGE_UP     = 5'd9;
  localparam logic [4:0] SCAN_PAGE_DOWN   = 5'd10;
  localparam logic [4:0] SCAN_F1          = 5'd11;
  localparam logic [4:0] SCAN_ESCAPE      = 5'd23;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_write;
  } rx_item_t;

  typedef struct packed {
    logic [4:0]  scan_code;
    logic [15:0] unicode_char;
    logic        last_of_run;
  } key_item_t;

  // one queue entry: everything a single byte asks the back end to emit
  typedef struct packed {
    logic               esc_first;
    logic               has_event;
    logic [4:0]         scan;
    logic [15:0]        ch;
    logic               flush;
    logic [FLUSH_W-1:0] flush_cnt;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ESC_A,
    BK_EVENT,
    BK_FLUSH_ESC,
    BK_BYTE
  } back_state_t;

  function automatic logic [4:0] tilde_key(input logic [4:0] num);
    case (num)
      5'd1:    return SCAN_HOME_KEY;
      5'd2:    return SCAN_INS;
      5'd3:    return SCAN_DEL;
      5'd4:    return SCAN_END_KEY;
      5'd5:    return SCAN_PAGE_UP;
      5'd6:    return SCAN_PAGE_DOWN;
      5'd15:   return SCAN_F1 + 5'd4;
      5'd17:   return SCAN_F1 + 5'd5;
      5'd18:   return SCAN_F1 + 5'd6;
      5'd19:   return SCAN_F1 + 5'd7;
      5'd20:   return SCAN_F1 + 5'd8;
      5'd21:   return SCAN_F1 + 5'd9;
      5'd23:   return SCAN_F1 + 5'd10;
      5'd24:   return SCAN_F1 + 5'd11;
      default: return SCAN_NONE;
    endcase
  endfunction

  function automatic logic [4:0] csi_final(input logic [7:0] b, input logic has_num,
                                           input logic [4:0] num);
    case (b)
      FIN_UP:    return SCAN_ARROW_UP;
      FIN_DOWN:  return SCAN_ARROW_DOWN;
      FIN_RIGHT: return SCAN_ARROW_RIGHT;
      FIN_LEFT:  return SCAN_ARROW_LEFT;
      FIN_HOME:  return SCAN_HOME_KEY;
      FIN_END:   return SCAN_END_KEY;
      FIN_TILDE: return has_num ? tilde_key(num) : SCAN_NONE;
      default:   return SCAN_NONE;
    endcase
  endfunction

endpackage

@@ rtl/core/terminal_escape_utf8_key_decoder.sv @@
// Top level of the terminal escape and UTF-8 key decoder.
// Takes one terminal byte per cycle unless rx_stall is high and produces key events (scan
// code or BMP character); last_of_run marks the final event caused by a byte. A bare ESC
// followed by a key yields an Esc event and then that key. When an escape is still open at
// end of write, the block emits Esc and then the held body bytes (up to 15), one per cycle
// read from the body RAM while key_stall allows, and takes no new byte until the back end
// has issued the last of them. A four-entry command queue separates byte intake from event
// output, so input keeps flowing while output is stalled until the queue fills. The body
// RAM needs no clearing after reset.
`timescale 1ns / 1ps
module terminal_escape_utf8_key_decoder import tekd_pkg::*; #(
  parameter int ESC_BODY_DEPTH = ESC_BODY_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      rx_valid,
  output logic      rx_stall,
  input  rx_item_t  rx_item,
  output logic      key_valid,
  input  logic      key_stall,
  output key_item_t key_item
);

  localparam int AW = $clog2(ESC_BODY_DEPTH);

  logic          push;
  cmd_t          cmd;
  logic          pop;
  cmd_t          head;
  logic          fifo_empty;
  logic          fifo_full;
  logic          flush_done;
  logic          body_wr_en;
  logic [AW-1:0] body_wr_addr;
  logic [7:0]    body_wr_data;
  logic          body_rd_en;
  logic [AW-1:0] body_rd_addr;
  logic [7:0]    body_rd_data;

  tekd_front #(
    .ESC_BODY_DEPTH(ESC_BODY_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .rx_valid    (rx_valid),
    .rx_stall    (rx_stall),
    .rx_item     (rx_item),
    .fifo_full   (fifo_full),
    .push        (push),
    .cmd         (cmd),
    .flush_done  (flush_done),
    .body_wr_en  (body_wr_en),
    .body_wr_addr(body_wr_addr),
    .body_wr_data(body_wr_data)
  );

  tekd_ram #(
    .WIDTH(8),
    .DEPTH(ESC_BODY_DEPTH)
  ) u_body_ram (
    .clk    (clk),
    .wr_en  (body_wr_en),
    .wr_addr(body_wr_addr),
    .wr_data(body_wr_data),
    .rd_en  (body_rd_en),
    .rd_addr(body_rd_addr),
    .rd_data(body_rd_data)
  );

  tekd_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(cmd),
    .pop      (pop),
    .head     (head),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  tekd_back #(
    .ESC_BODY_DEPTH(ESC_BODY_DEPTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .fifo_empty  (fifo_empty),
    .head        (head),
    .pop         (pop),
    .key_valid   (key_valid),
    .key_stall   (key_stall),
    .key_item    (key_item),
    .body_rd_en  (body_rd_en),
    .body_rd_addr(body_rd_addr),
    .body_rd_data(body_rd_data),
    .flush_done  (flush_done)
  );

endmodule

@@ rtl/core/tekd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tekd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/tekd_front.sv @@
// Front end: byte intake, escape and UTF-8 state, command generation.
`timescale 1ns / 1ps
module tekd_front import tekd_pkg::*; #(
  parameter int ESC_BODY_DEPTH = ESC_BODY_DEPTH_DEF,
  localparam int AW    = $clog2(ESC_BODY_DEPTH),
  localparam int CNT_W = $clog2(ESC_BODY_DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rx_valid,
  output logic          rx_stall,
  input  rx_item_t      rx_item,
  input  logic          fifo_full,
  output logic          push,
  output cmd_t          cmd,
  input  logic          flush_done,
  output logic          body_wr_en,
  output logic [AW-1:0] body_wr_addr,
  output logic [7:0]    body_wr_data
);

  localparam int CMP_W = (CNT_W > FLUSH_W) ? CNT_W : FLUSH_W;

  logic             esc_open, esc_open_next;
  logic [CNT_W-1:0] esc_count, esc_count_next;
  logic             ss3, ss3_next;
  logic [4:0]       csi_num, csi_num_next;
  logic             csi_has, csi_has_next;
  logic             csi_skip, csi_skip_next;
  logic [15:0]      utf_partial, utf_partial_next;
  logic [1:0]       utf_need, utf_need_next;
  logic [7:0]       utf_held, utf_held_next;
  logic             flush_wait;

  logic             accept;
  logic             wr_req;
  logic             do_plain;
  logic             esc_done;
  logic [4:0]       esc_scan;
  logic [8:0]       num_sum;
  logic [CNT_W-1:0] cnt_inc;
  logic [7:0]       b;
  logic             eow;

  assign b        = rx_item.byte_value;
  assign eow      = rx_item.end_of_write;
  // hold input while an end-of-write flush still reads the body RAM or the command queue is full
  assign rx_stall = flush_wait || fifo_full;
  assign accept   = rx_valid && !rx_stall;
  assign push     = accept && (cmd.esc_first || cmd.has_event || cmd.flush);

  assign body_wr_en   = accept && wr_req;
  assign body_wr_addr = AW'(esc_count);
  assign body_wr_data = b;

  always_comb begin
    esc_open_next    = esc_open;
    esc_count_next   = esc_count;
    ss3_next         = ss3;
    csi_num_next     = csi_num;
    csi_has_next     = csi_has;
    csi_skip_next    = csi_skip;
    utf_partial_next = utf_partial;
    utf_need_next    = utf_need;
    utf_held_next    = utf_held;
    cmd              = '0;
    wr_req           = 1'b0;
    do_plain         = 1'b0;
    esc_done         = 1'b0;
    esc_scan         = SCAN_NONE;
    cnt_inc          = esc_count + CNT_W'(1);
    num_sum          = {1'b0, csi_num, 3'b000} + {3'b000, csi_num, 1'b0} + {5'b00000, b[3:0]};

    if (utf_need == 2'd1) begin
      cmd.has_event    = 1'b1;
      cmd.ch           = utf_partial | {4'b0000, utf_held[5:0], 6'b000000}
                         | {10'b0, b[5:0]};
      utf_need_next    = 2'd0;
      utf_held_next    = 8'h00;
      utf_partial_next = 16'h0000;
    end else if (utf_need >= 2'd2) begin
      if (eow) begin
        // three-byte lead cut short: drop it, take this byte as new
        utf_need_next    = 2'd0;
        utf_partial_next = 16'h0000;
        do_plain         = 1'b1;
      end else begin
        utf_held_next = b;
        utf_need_next = 2'd1;
      end
    end else if (esc_open) begin
      if (esc_count == '0 && b != INTRO_CSI && b != INTRO_SS3) begin
        // bare ESC: Esc key, then the byte as usual
        cmd.esc_first  = 1'b1;
        esc_open_next  = 1'b0;
        esc_count_next = '0;
        csi_num_next   = 5'd0;
        csi_has_next   = 1'b0;
        csi_skip_next  = 1'b0;
        do_plain       = 1'b1;
      end else begin
        wr_req         = 1'b1;
        esc_count_next = cnt_inc;
        if (esc_count == '0) begin
          csi_num_next  = 5'd0;
          csi_has_next  = 1'b0;
          csi_skip_next = 1'b0;
          ss3_next      = (b == INTRO_SS3);
        end else if (ss3) begin
          esc_done = 1'b1;
          if (b >= SS3_P && b <= SS3_S) begin
            esc_scan = SCAN_F1 + 5'(b - SS3_P);
          end
        end else if (csi_skip) begin
          if (b == FIN_TILDE || (b >= CH_AT && b <= CH_Z)) begin
            esc_done = 1'b1;
            esc_scan = csi_final(b, csi_has, csi_num);
          end
        end else if (b >= CH_0 && b <= CH_9) begin
          csi_num_next = (num_sum > 9'(CSI_NUM_MAX)) ? CSI_NUM_MAX : num_sum[4:0];
          csi_has_next = 1'b1;
        end else if (b == CH_SEMI) begin
          csi_skip_next = 1'b1;
        end else begin
          esc_done = 1'b1;
          esc_scan = csi_final(b, csi_has, csi_num);
        end

        if (esc_done || cnt_inc >= CNT_W'(ESC_BODY_DEPTH)) begin
          if (esc_done && esc_scan != SCAN_NONE) begin
            cmd.has_event = 1'b1;
            cmd.scan      = esc_scan;
          end
          esc_open_next  = 1'b0;
          esc_count_next = '0;
          csi_num_next   = 5'd0;
          csi_has_next   = 1'b0;
          csi_skip_next  = 1'b0;
        end
      end
    end else begin
      do_plain = 1'b1;
    end

    if (do_plain) begin
      if (b == BYTE_ESC) begin
        esc_open_next  = 1'b1;
        esc_count_next = '0;
        csi_num_next   = 5'd0;
        csi_has_next   = 1'b0;
        csi_skip_next  = 1'b0;
      end else if (!b[7]) begin
        cmd.has_event = 1'b1;
        cmd.ch        = {8'h00, (b == BYTE_DEL) ? CHAR_BS : b};
      end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
        if (!eow) begin
          utf_partial_next = {5'b00000, b[4:0], 6'b000000};
          utf_held_next    = 8'h00;
          utf_need_next    = 2'd1;
        end
      end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
        if (!eow) begin
          utf_partial_next = {b[3:0], 12'h000};
          utf_held_next    = 8'h00;
          utf_need_next    = 2'd2;
        end
      end
    end

    // end of write with an escape still open: Esc plus the body as text
    if (eow && esc_open_next) begin
      cmd.flush      = 1'b1;
      cmd.flush_cnt  = (CMP_W'(esc_count_next) > CMP_W'(FLUSH_MAX)) ? FLUSH_MAX
                                                                     : FLUSH_W'(esc_count_next);
      esc_open_next  = 1'b0;
      esc_count_next = '0;
      csi_num_next   = 5'd0;
      csi_has_next   = 1'b0;
      csi_skip_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      esc_open    <= 1'b0;
      esc_count   <= '0;
      ss3         <= 1'b0;
      csi_num     <= 5'd0;
      csi_has     <= 1'b0;
      csi_skip    <= 1'b0;
      utf_partial <= 16'h0000;
      utf_need    <= 2'd0;
      utf_held    <= 8'h00;
    end else if (accept) begin
      esc_open    <= esc_open_next;
      esc_count   <= esc_count_next;
      ss3         <= ss3_next;
      csi_num     <= csi_num_next;
      csi_has     <= csi_has_next;
      csi_skip    <= csi_skip_next;
      utf_partial <= utf_partial_next;
      utf_need    <= utf_need_next;
      utf_held    <= utf_held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flush_wait <= 1'b0;
    end else if (accept && cmd.flush) begin
      flush_wait <= 1'b1;
    end else if (flush_done) begin
      flush_wait <= 1'b0;
    end
  end

endmodule

@@ rtl/core/tekd_cmd_fifo.sv @@
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module tekd_cmd_fifo import tekd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t head,
  output logic empty,
  output logic full
);

  localparam int PW = $clog2(CMD_FIFO_DEPTH);
  localparam int CW = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t          entries [CMD_FIFO_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == CW'(CMD_FIFO_DEPTH));
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

@@ rtl/core/tekd_back.sv @@
// Back end: walks each command and drives key events into the output register.
`timescale 1ns / 1ps
module tekd_back import tekd_pkg::*; #(
  parameter int ESC_BODY_DEPTH = ESC_BODY_DEPTH_DEF,
  localparam int AW = $clog2(ESC_BODY_DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          fifo_empty,
  input  cmd_t          head,
  output logic          pop,
  output logic          key_valid,
  input  logic          key_stall,
  output key_item_t     key_item,
  output logic          body_rd_en,
  output logic [AW-1:0] body_rd_addr,
  input  logic [7:0]    body_rd_data,
  output logic          flush_done
);

  back_state_t        state, state_next;
  cmd_t               cur, cur_next;
  logic [FLUSH_W-1:0] idx, idx_next;
  logic [FLUSH_W-1:0] idx_inc;
  logic               out_free;
  logic               emit;
  logic               fin;
  key_item_t          item;

  assign out_free = !key_valid || !key_stall;
  assign idx_inc  = idx + FLUSH_W'(1);

  always_comb begin
    state_next   = state;
    cur_next     = cur;
    idx_next     = idx;
    pop          = 1'b0;
    emit         = 1'b0;
    fin          = 1'b0;
    item         = '0;
    body_rd_en   = 1'b0;
    body_rd_addr = '0;
    flush_done   = 1'b0;

    case (state)
      BK_IDLE: begin
      end
      BK_ESC_A: begin
        if (out_free) begin
          emit           = 1'b1;
          item.scan_code = SCAN_ESCAPE;
          if (cur.has_event) begin
            state_next = BK_EVENT;
          end else if (cur.flush) begin
            state_next = BK_FLUSH_ESC;
          end else begin
            fin = 1'b1;
          end
        end
      end
      BK_EVENT: begin
        if (out_free) begin
          emit              = 1'b1;
          item.scan_code    = cur.scan;
          item.unicode_char = cur.ch;
          if (cur.flush) begin
            state_next = BK_FLUSH_ESC;
          end else begin
            fin = 1'b1;
          end
        end
      end
      BK_FLUSH_ESC: begin
        if (out_free) begin
          emit           = 1'b1;
          item.scan_code = SCAN_ESCAPE;
          if (cur.flush_cnt != '0) begin
            // prefetch body byte 0 for the BK_BYTE state
            body_rd_en = 1'b1;
            idx_next   = '0;
            state_next = BK_BYTE;
          end else begin
            fin        = 1'b1;
            flush_done = 1'b1;
          end
        end
      end
      BK_BYTE: begin
        if (out_free) begin
          emit              = 1'b1;
          item.unicode_char = {8'h00, body_rd_data};
          if (idx_inc < cur.flush_cnt) begin
            idx_next     = idx_inc;
            body_rd_en   = 1'b1;
            body_rd_addr = AW'(idx_inc);
          end else begin
            fin        = 1'b1;
            flush_done = 1'b1;
          end
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase

    item.last_of_run = fin;

    if ((state == BK_IDLE || fin) && !fifo_empty) begin
      pop      = 1'b1;
      cur_next = head;
      if (head.esc_first) begin
        state_next = BK_ESC_A;
      end else if (head.has_event) begin
        state_next = BK_EVENT;
      end else begin
        state_next = BK_FLUSH_ESC;
      end
    end else if (fin) begin
      state_next = BK_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    idx <= idx_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else if (out_free) begin
      key_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && emit) begin
      key_item <= item;
    end
  end

endmodule

@@ rtl/core/tekd_checker.sv @@
// Port-level assertions for the key decoder, bound to the top level.
`timescale 1ns / 1ps
module tekd_checker import tekd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      rx_valid,
  input logic      rx_stall,
  input rx_item_t  rx_item,
  input logic      key_valid,
  input logic      key_stall,
  input key_item_t key_item
);

  // a stalled byte transfer holds its payload
  a_rx_hold: assert property (@(posedge clk) disable iff (rst)
    rx_valid && rx_stall |=> rx_valid && $stable(rx_item))
    else $error("byte changed while stalled");

  // a stalled key transfer holds its event
  a_key_hold: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_stall |=> key_valid && $stable(key_item))
    else $error("key event changed while stalled");

  // scan keys carry no character
  a_scan_no_char: assert property (@(posedge clk) disable iff (rst)
    key_valid && key_item.scan_code != SCAN_NONE |-> key_item.unicode_char == 16'h0000)
    else $error("scan key with nonzero character");

  a_scan_range: assert property (@(posedge clk) disable iff (rst)
    key_valid |-> key_item.scan_code <= SCAN_ESCAPE)
    else $error("scan code out of range");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !key_valid)
    else $error("key output valid right after reset");

endmodule

bind terminal_escape_utf8_key_decoder tekd_checker u_tekd_checker (
  .clk      (clk),
  .rst      (rst),
  .rx_valid (rx_valid),
  .rx_stall (rx_stall),
  .rx_item  (rx_item),
  .key_valid(key_valid),
  .key_stall(key_stall),
  .key_item (key_item)
);

@@ tb/testbench.sv @@
// Self-checking testbench for the terminal escape and UTF-8 key decoder.
`timescale 1ns / 1ps
module testbench;
  import tekd_pkg::*;

  localparam int STALL_LIMIT = 3000;  // cycles with no transfer on either side
  localparam int RANDOM_BYTES = 230;

  // Tracks the decoder state, predicts the key events of every accepted byte
  // and checks the events that leave the block in order.
  class key_event_board;
    bit        esc_open;
    bit [4:0]  esc_count;
    bit [7:0]  esc_body [ESC_BODY_DEPTH_DEF];
    bit [4:0]  csi_num;
    bit        csi_num_seen;
    bit        csi_mods;
    bit [15:0] utf_acc;
    bit [1:0]  utf_need;
    bit [7:0]  utf_mid;
    key_item_t run_keys[$];
    key_item_t expected_keys[$];
    int mismatches, bytes_taken, scan_keys, char_keys, longest_run;

    function void push_key(logic [4:0] scan, logic [15:0] ch);
      key_item_t k;
      k.scan_code    = scan;
      k.unicode_char = ch;
      k.last_of_run  = 1'b0;
      // a single byte never yields more than RESULT_LIMIT events
      if (run_keys.size() < RESULT_LIMIT) run_keys.push_back(k);
    endfunction

    function void clear_escape();
      esc_open     = 1'b0;
      esc_count    = '0;
      csi_num      = '0;
      csi_num_seen = 1'b0;
      csi_mods     = 1'b0;
    endfunction

    function logic [4:0] number_scan(logic [4:0] n);
      case (n)
        5'd1:    return SCAN_HOME_KEY;
        5'd2:    return SCAN_INS;
        5'd3:    return SCAN_DEL;
        5'd4:    return SCAN_END_KEY;
        5'd5:    return SCAN_PAGE_UP;
        5'd6:    return SCAN_PAGE_DOWN;
        5'd15, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21:
          // F5 is 15, F6..F10 are 17..21
          return (n == 5'd15) ? SCAN_F1 + 5'd4 : SCAN_F1 + (n - 5'd12);
        5'd23, 5'd24:
          return SCAN_F1 + (n - 5'd13);
        default: return SCAN_NONE;
      endcase
    endfunction

    function logic [4:0] final_scan(logic [7:0] b);
      case (b)
        FIN_UP:    return SCAN_ARROW_UP;
        FIN_DOWN:  return SCAN_ARROW_DOWN;
        FIN_RIGHT: return SCAN_ARROW_RIGHT;
        FIN_LEFT:  return SCAN_ARROW_LEFT;
        FIN_HOME:  return SCAN_HOME_KEY;
        FIN_END:   return SCAN_END_KEY;
        FIN_TILDE: return csi_num_seen ? number_scan(csi_num) : SCAN_NONE;
        default:   return SCAN_NONE;
      endcase
    endfunction

    function void plain_byte(logic [7:0] b, logic eow);
      if (b == BYTE_ESC) begin
        clear_escape();
        esc_open = 1'b1;
      end else if (b < 8'h80) begin
        push_key(SCAN_NONE, {8'h00, (b == BYTE_DEL) ? CHAR_BS : b});
      end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
        if (!eow) begin
          utf_acc  = {5'b0, b[4:0], 6'b0};
          utf_mid  = '0;
          utf_need = 2'd1;
        end
      end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
        if (!eow) begin
          utf_acc  = {b[3:0], 12'b0};
          utf_mid  = '0;
          utf_need = 2'd2;
        end
      end
    endfunction

    function void body_byte(logic [7:0] b);
      int         idx;
      int         v;
      bit         done;
      logic [4:0] scan;
      idx  = esc_count;
      done = 1'b0;
      scan = SCAN_NONE;
      if (idx < ESC_BODY_DEPTH_DEF) begin
        esc_body[idx] = b;
        esc_count     = 5'(idx + 1);
      end
      if (idx == 0) begin
        csi_num      = '0;
        csi_num_seen = 1'b0;
        csi_mods     = 1'b0;
      end else if (esc_body[0] == INTRO_SS3) begin
        done = 1'b1;
        if (b >= SS3_P && b <= SS3_S) scan = SCAN_F1 + 5'(b - SS3_P);
      end else if (csi_mods) begin
        if (b == FIN_TILDE || (b >= CH_AT && b <= CH_Z)) begin
          done = 1'b1;
          scan = final_scan(b);
        end
      end else if (b >= CH_0 && b <= CH_9) begin
        v            = int'(csi_num) * 10 + int'(b - CH_0);
        csi_num      = (v > 31) ? CSI_NUM_MAX : 5'(v);
        csi_num_seen = 1'b1;
      end else if (b == CH_SEMI) begin
        csi_mods = 1'b1;
      end else begin
        done = 1'b1;
        scan = final_scan(b);
      end
      if (done) begin
        if (scan != SCAN_NONE) push_key(scan, 16'h0000);
        clear_escape();
      end else if (esc_count >= ESC_BODY_DEPTH_DEF) begin
        // overfull body is dropped without any event
        clear_escape();
      end
    endfunction

    function void take_byte(rx_item_t it);
      logic [7:0]  b;
      logic        eow;
      logic [15:0] cp;
      key_item_t   k;
      b   = it.byte_value;
      eow = it.end_of_write;
      run_keys.delete();
      if (utf_need == 2'd1) begin
        cp       = utf_acc | {4'b0, utf_mid[5:0], 6'b0} | {10'b0, b[5:0]};
        utf_need = '0;
        utf_mid  = '0;
        utf_acc  = '0;
        push_key(SCAN_NONE, cp);
      end else if (utf_need >= 2'd2) begin
        if (eow) begin
          // three-byte lead cut short: the byte stands on its own
          utf_need = '0;
          utf_acc  = '0;
          plain_byte(b, eow);
        end else begin
          utf_mid  = b;
          utf_need = 2'd1;
        end
      end else if (esc_open) begin
        if (esc_count == 0 && b != INTRO_CSI && b != INTRO_SS3) begin
          push_key(SCAN_ESCAPE, 16'h0000);
          clear_escape();
          plain_byte(b, eow);
        end else begin
          body_byte(b);
        end
      end else begin
        plain_byte(b, eow);
      end
      if (eow && esc_open) begin
        push_key(SCAN_ESCAPE, 16'h0000);
        for (int j = 0; j < esc_count; j++) push_key(SCAN_NONE, {8'h00, esc_body[j]});
        clear_escape();
      end
      if (run_keys.size() != 0) begin
        k = run_keys.pop_back();
        k.last_of_run = 1'b1;
        run_keys.push_back(k);
        if (run_keys.size() > longest_run) longest_run = run_keys.size();
      end
      foreach (run_keys[i]) expected_keys.push_back(run_keys[i]);
      run_keys.delete();
      bytes_taken++;
    endfunction

    function void check_key(key_item_t got);
      key_item_t want;
      if (expected_keys.size() == 0) begin
        mismatches++;
        $display("%0t: key event with none expected: scan %0d char %h last %b",
                 $time, got.scan_code, got.unicode_char, got.last_of_run);
        return;
      end
      want = expected_keys.pop_front();
      if (want.scan_code != SCAN_NONE) scan_keys++;
      else char_keys++;
      if (got.scan_code !== want.scan_code || got.unicode_char !== want.unicode_char ||
          got.last_of_run !== want.last_of_run) begin
        mismatches++;
        $display("%0t: key mismatch: expected scan %0d char %h last %b, %s",
                 $time, want.scan_code, want.unicode_char, want.last_of_run,
                 $sformatf("got scan %0d char %h last %b",
                           got.scan_code, got.unicode_char, got.last_of_run));
      end
    endfunction
  endclass

  logic      clk;
  logic      rst;
  logic      rx_valid;
  logic      rx_stall;
  rx_item_t  rx_item;
  logic      key_valid;
  logic      key_stall;
  key_item_t key_item;

  key_event_board board;
  bit calm;          // no gaps and no new stalls while set
  int stall_left;
  int stall_pick;
  int idle_cycles;

  terminal_escape_utf8_key_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_item   (rx_item),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_item  (key_item)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // receiver back-pressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      key_stall  <= 1'b1;
    end else if (rst || calm) begin
      key_stall <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 60) begin
        key_stall <= 1'b0;
      end else begin
        key_stall  <= 1'b1;
        stall_left <= (stall_pick < 92) ? $urandom_range(0, 2) : $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && key_valid === 1'b1 && key_stall === 1'b0) board.check_key(key_item);
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && rx_stall === 1'b0) || (key_valid === 1'b1 && !key_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d key events still expected",
               $time, STALL_LIMIT, board.expected_keys.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int next_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eow);
    rx_item_t it;
    int       gap;
    it.byte_value   = b;
    it.end_of_write = eow;
    rx_valid <= 1'b1;
    rx_item  <= it;
    do @(posedge clk); while (rx_stall !== 1'b0);
    board.take_byte(it);
    gap = next_gap();
    if (gap != 0) begin
      rx_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One random burst: mostly well-formed key sequences with random content,
  // plus noise and writes that end in the middle of a sequence.
  task automatic random_sequence();
    logic [7:0] seq[$];
    string      digits;
    int         n;
    bit         end_write;
    case ($urandom_range(0, 11))
      0, 1: seq.push_back(8'($urandom_range(32, 126)));
      2: begin
        seq.push_back(BYTE_ESC);
        seq.push_back(INTRO_SS3);
        seq.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                   : SS3_P + 8'($urandom_range(0, 3)));
      end
      3: begin
        seq.push_back(BYTE_ESC);
        seq.push_back(INTRO_CSI);
        case ($urandom_range(0, 7))
          0: seq.push_back(FIN_UP);
          1: seq.push_back(FIN_DOWN);
          2: seq.push_back(FIN_RIGHT);
          3: seq.push_back(FIN_LEFT);
          4: seq.push_back(FIN_HOME);
          5: seq.push_back(FIN_END);
          6: seq.push_back(8'($urandom_range(8'h40, 8'h7E)));
          default: seq.push_back(8'($urandom_range(8'h20, 8'h7F)));
        endcase
      end
      4: begin
        seq.push_back(BYTE_ESC);
        seq.push_back(INTRO_CSI);
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 400) : $urandom_range(1, 24);
        digits = $sformatf("%0d", n);
        for (int i = 0; i < digits.len(); i++) seq.push_back(digits[i]);
        if ($urandom_range(0, 2) == 0) begin
          seq.push_back(CH_SEMI);
          seq.push_back(CH_0 + 8'($urandom_range(0, 9)));
        end
        seq.push_back(($urandom_range(0, 4) == 0) ? FIN_UP + 8'($urandom_range(0, 7))
                                                   : FIN_TILDE);
      end
      5: begin
        seq.push_back(BYTE_ESC);
        seq.push_back(8'($urandom_range(0, 255)));
      end
      6: begin
        seq.push_back(8'hC0 | 8'($urandom_range(0, 31)));
        seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end
      7: begin
        seq.push_back(8'hE0 | 8'($urandom_range(0, 15)));
        seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
        seq.push_back(8'h80 | 8'($urandom_range(0, 63)));
      end
      8: begin
        n = $urandom_range(1, 3);
        repeat (n) seq.push_back(8'($urandom_range(0, 255)));
      end
      9: begin
        // bodies of up to 17 bytes, often near and past the body depth
        seq.push_back(BYTE_ESC);
        seq.push_back(INTRO_CSI);
        n = $urandom_range(0, 1) ? $urandom_range(13, 16) : $urandom_range(0, 12);
        for (int i = 0; i < n; i++) begin
          if (i == 0) seq.push_back(CH_SEMI);
          else if ($urandom_range(0, 1)) seq.push_back(CH_0 + 8'($urandom_range(0, 9)));
          else seq.push_back(8'($urandom_range(8'h61, 8'h7A)));
        end
      end
      10: begin
        seq.push_back(BYTE_ESC);
        n = $urandom_range(0, 3);
        repeat (n) seq.push_back(8'($urandom_range(0, 255)));
        end_write = 1'b1;
      end
      default: seq.push_back(($urandom_range(0, 1) == 0) ? BYTE_DEL
                                                          : 8'($urandom_range(0, 31)));
    endcase
    if (!end_write) end_write = ($urandom_range(0, 3) == 0);
    foreach (seq[i])
      send_byte(seq[i], (i == seq.size() - 1 && end_write) || $urandom_range(0, 19) == 0);
  endtask

  initial begin
    bit drained;
    board     = new();
    rst       = 1'b1;
    rx_valid  = 1'b0;
    rx_item   = '0;
    key_stall = 1'b0;
    calm      = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(8'h00, 1'b0);
    send_byte(BYTE_DEL, 1'b0);
    send_byte(BYTE_ESC, 1'b0); send_byte(INTRO_SS3, 1'b0); send_byte(SS3_P, 1'b0);
    // Delete with a modifier field
    send_byte(BYTE_ESC, 1'b0); send_byte(INTRO_CSI, 1'b0); send_byte("3", 1'b0);
    send_byte(CH_SEMI, 1'b0);  send_byte(FIN_TILDE, 1'b0);
    // bare Esc, then an invalid lead that is dropped
    send_byte(BYTE_ESC, 1'b0); send_byte(8'hFF, 1'b0);
    // continuation taken whatever its value
    send_byte(8'hE2, 1'b0); send_byte(BYTE_ESC, 1'b0); send_byte(8'hAC, 1'b0);
    send_byte(8'hC3, 1'b1);                           // lead ends the write
    send_byte(8'hE2, 1'b0); send_byte("z", 1'b1);     // three-byte lead cut short
    send_byte(8'h80, 1'b0);                           // stray continuation
    send_byte(BYTE_ESC, 1'b0); send_byte(INTRO_CSI, 1'b0); send_byte(FIN_TILDE, 1'b0);
    // number saturates and matches nothing
    send_byte(BYTE_ESC, 1'b0); send_byte(INTRO_CSI, 1'b0); send_byte("4", 1'b0);
    send_byte("0", 1'b0);      send_byte(FIN_TILDE, 1'b0);
    // escape still open when the write ends
    send_byte(BYTE_ESC, 1'b0); send_byte(INTRO_CSI, 1'b0); send_byte("1", 1'b0);
    send_byte("2", 1'b1);

    drained = 1'b0;
    while (board.bytes_taken < RANDOM_BYTES) begin
      calm = ((board.bytes_taken / 40) % 3 == 1);
      if (!drained && board.bytes_taken >= 120) begin
        rx_valid <= 1'b0;
        while (board.expected_keys.size() != 0) @(posedge clk);
        @(posedge clk);
        drained = 1'b1;
      end
      random_sequence();
    end
    calm = 1'b0;

    rx_valid <= 1'b0;
    while (board.expected_keys.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("Covered %0d bytes giving %0d key events (%0d scan keys, %0d characters).",
             board.bytes_taken, board.scan_keys + board.char_keys, board.scan_keys,
             board.char_keys);
    $display("Longest burst from one byte: %0d events; %0d mismatches.",
             board.longest_run, board.mismatches);
    if (board.mismatches == 0 && board.expected_keys.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/tekd_pkg.sv
rtl/core/tekd_ram.sv
rtl/core/tekd_front.sv
rtl/core/tekd_cmd_fifo.sv
rtl/core/tekd_back.sv
rtl/core/terminal_escape_utf8_key_decoder.sv
rtl/core/tekd_checker.sv
tb/testbench.sv
